>>> rtl/frsa_pkg.sv
// Package for the fenced ring space allocator: widths, codes, command type.
`timescale 1ns / 1ps
`default_nettype none
package frsa_pkg;

	localparam int FRAME_QUEUE_DEPTH_DEF = 8;
	localparam int OFFSET_BITS_DEF       = 32;

	localparam int MODE_W   = 2;
	localparam int SIZE_W   = 32;
	localparam int FENCE_W  = 64;
	localparam int CAP_W    = 32;
	localparam int STATUS_W = 2;
	localparam int REGION_W = 32;
	localparam int USED_W   = 32;
	localparam int PEND_W   = 4;

	localparam logic [63:0] CAP_RESET = 64'd65536;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ALLOC,
		OP_FINISH,
		OP_RELEASE
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_RELEASE
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [SIZE_W-1:0]  size;
		logic [FENCE_W-1:0] fence;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/frsa_req_if.sv
// Request channel interface: mode, size and fence per beat.
`timescale 1ns / 1ps
`default_nettype none
interface frsa_req_if;
	import frsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SIZE_W-1:0]   request_size;
	logic [FENCE_W-1:0]  fence_value;

	modport source (output valid, output mode, output request_size, output fence_value,
		input ready);
	modport sink (input valid, input mode, input request_size, input fence_value,
		output ready);
endinterface
`default_nettype wire

>>> rtl/frsa_rsp_if.sv
// Result channel interface: status, region offset, used space, pending frames.
`timescale 1ns / 1ps
`default_nettype none
interface frsa_rsp_if;
	import frsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [REGION_W-1:0] region_offset;
	logic [USED_W-1:0]   used_space;
	logic [PEND_W-1:0]   pending_frames;

	modport source (output valid, output status, output region_offset, output used_space,
		output pending_frames, input ready);
	modport sink (input valid, input status, input region_offset, input used_space,
		input pending_frames, output ready);
endinterface
`default_nettype wire

>>> rtl/frsa_front.sv
// Front end: accepts request beats, decodes mode and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module frsa_front (
	input  wire              clk,
	input  wire              arst_n,
	frsa_req_if.sink         req,
	output logic             cmd_valid,
	output frsa_pkg::cmd_t   cmd,
	input  wire              cmd_pop
);
	import frsa_pkg::*;

	cmd_t       q_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       dec;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rptr_q];

	always_comb begin
		dec.size  = req.request_size;
		dec.fence = req.fence_value;
		unique case (req.mode)
			MODE_ALLOC:   dec.op = OP_ALLOC;
			MODE_FINISH:  dec.op = OP_FINISH;
			MODE_RELEASE: dec.op = OP_RELEASE;
			default:      dec.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/frsa_back.sv
// Back end: ring state, frame queue, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none
module frsa_back #(
	parameter int FRAME_QUEUE_DEPTH = frsa_pkg::FRAME_QUEUE_DEPTH_DEF,
	parameter int OFFSET_BITS       = frsa_pkg::OFFSET_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [frsa_pkg::CAP_W-1:0] cfg_wdata,
	input  wire                       cmd_valid,
	input  frsa_pkg::cmd_t            cmd,
	output logic                      cmd_pop,
	frsa_rsp_if.source                rsp
);
	import frsa_pkg::*;

	localparam int OW = OFFSET_BITS;
	localparam int AW = ((OW > SIZE_W) ? OW : SIZE_W) + 1;
	localparam int PW = $clog2(FRAME_QUEUE_DEPTH);
	localparam int CW = $clog2(FRAME_QUEUE_DEPTH + 1);
	localparam logic [OW-1:0] CAP_RST = CAP_RESET[OW-1:0];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(FRAME_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [OW-1:0]      cap_q, tail_q, head_q, held_q, frame_q;
	logic [FENCE_W-1:0] qfence_q [FRAME_QUEUE_DEPTH];
	logic [OW-1:0]      qtail_q  [FRAME_QUEUE_DEPTH];
	logic [OW-1:0]      qspace_q [FRAME_QUEUE_DEPTH];
	logic [PW-1:0]      rptr_q, wptr_q;
	logic [CW-1:0]      cnt_q;
	back_state_t        state_q, state_d;
	logic [FENCE_W-1:0] fence_q;

	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [REGION_W-1:0] region_q;

	logic res_free, pop_ok, do_exec, do_pop, do_emit_rel, res_set;
	logic q_full;

	// allocation datapath
	logic [AW-1:0] tail_x, head_x, cap_x, size_x, end_x, chg_x, skip_x;
	logic [OW-1:0] skipped, alloc_tail, alloc_where;
	logic          alloc_ok;
	logic [63:0]   where64, held64, cfg64;
	logic [63:0]   cnt64;

	assign tail_x = {{(AW-OW){1'b0}}, tail_q};
	assign head_x = {{(AW-OW){1'b0}}, head_q};
	assign cap_x  = {{(AW-OW){1'b0}}, cap_q};
	assign size_x = {{(AW-SIZE_W){1'b0}}, cmd.size};
	assign end_x  = tail_x + size_x;
	assign skipped = (cap_q >= tail_q) ? cap_q - tail_q : '0;
	assign skip_x  = {{(AW-OW){1'b0}}, skipped} + size_x;

	always_comb begin
		alloc_ok    = 1'b0;
		alloc_tail  = tail_q;
		alloc_where = '0;
		chg_x       = '0;
		if (held_q >= cap_q) begin
			alloc_ok = 1'b0;
		end else if (tail_q >= head_q) begin
			if (end_x <= cap_x) begin
				alloc_ok    = 1'b1;
				alloc_where = tail_q;
				alloc_tail  = end_x[OW-1:0];
				chg_x       = size_x;
			end else if (size_x <= head_x) begin
				alloc_ok    = 1'b1;
				alloc_where = '0;
				alloc_tail  = size_x[OW-1:0];
				chg_x       = skip_x;
			end
		end else if (end_x <= head_x) begin
			alloc_ok    = 1'b1;
			alloc_where = tail_q;
			alloc_tail  = end_x[OW-1:0];
			chg_x       = size_x;
		end
	end

	assign q_full   = (cnt_q >= CW'(FRAME_QUEUE_DEPTH));
	assign res_free = !res_valid_q || rsp.ready;
	assign pop_ok   = (cnt_q != '0) && (qfence_q[rptr_q] <= fence_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && res_free && cmd.op == OP_RELEASE) begin
					state_d = BK_RELEASE;
				end
			end
			BK_RELEASE: begin
				if (!pop_ok && res_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		do_exec     = 1'b0;
		do_pop      = 1'b0;
		do_emit_rel = 1'b0;
		unique case (state_q)
			BK_IDLE:    do_exec = cmd_valid && res_free;
			BK_RELEASE: begin
				do_pop      = pop_ok;
				do_emit_rel = !pop_ok && res_free;
			end
			default: ;
		endcase
	end

	assign cmd_pop = do_exec;
	assign res_set = (do_exec && cmd.op != OP_RELEASE) || do_emit_rel;

	assign cfg64   = {32'b0, cfg_wdata};
	assign where64 = {{(64-OW){1'b0}}, alloc_where};
	assign held64  = {{(64-OW){1'b0}}, held_q};
	assign cnt64   = {{(64-CW){1'b0}}, cnt_q};

	assign rsp.valid          = res_valid_q;
	assign rsp.status         = status_q;
	assign rsp.region_offset  = region_q;
	assign rsp.used_space     = held64[USED_W-1:0];
	assign rsp.pending_frames = cnt64[PEND_W-1:0];

	always_ff @(posedge clk) begin
		if (do_exec && cmd.op == OP_FINISH && !q_full) begin
			qfence_q[wptr_q] <= cmd.fence;
			qtail_q[wptr_q]  <= tail_q;
			qspace_q[wptr_q] <= frame_q;
		end
		if (do_exec) begin
			fence_q <= cmd.fence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RST;
			tail_q      <= '0;
			head_q      <= '0;
			held_q      <= '0;
			frame_q     <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			cnt_q       <= '0;
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
			status_q    <= ST_OK;
			region_q    <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg64[OW-1:0];
			tail_q  <= '0;
			head_q  <= '0;
			held_q  <= '0;
			frame_q <= '0;
			rptr_q  <= '0;
			wptr_q  <= '0;
			cnt_q   <= '0;
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			if (do_exec) begin
				unique case (cmd.op)
					OP_ALLOC: begin
						if (alloc_ok) begin
							status_q <= ST_OK;
							region_q <= where64[REGION_W-1:0];
							tail_q   <= alloc_tail;
							held_q   <= held_q + chg_x[OW-1:0];
							frame_q  <= frame_q + chg_x[OW-1:0];
						end else begin
							status_q <= ST_NO_SPACE;
							region_q <= '0;
						end
					end
					OP_FINISH: begin
						region_q <= '0;
						if (q_full) begin
							status_q <= ST_OVERFLOW;
						end else begin
							status_q <= ST_OK;
							wptr_q   <= ptr_inc(wptr_q);
							cnt_q    <= cnt_q + 1'b1;
							frame_q  <= '0;
						end
					end
					OP_RELEASE: ;
					OP_NOP: begin
						status_q <= ST_OK;
						region_q <= '0;
					end
					default: ;
				endcase
			end
			if (do_pop) begin
				held_q <= (qspace_q[rptr_q] <= held_q) ? held_q - qspace_q[rptr_q] : '0;
				head_q <= qtail_q[rptr_q];
				rptr_q <= ptr_inc(rptr_q);
				cnt_q  <= cnt_q - 1'b1;
			end
			if (do_emit_rel) begin
				status_q <= ST_OK;
				region_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/fenced_ring_space_allocator.sv
// Top level of the fenced ring space allocator.
//
// req carries one command per beat: mode 0 allocates request_size units at
// the ring tail (wrapping to offset 0 when the tail space is short), mode 1
// queues the current frame with fence_value, mode 2 releases frames from the
// queue head while their fence is at or below fence_value. rsp returns one
// beat per command: status, region offset, used space and pending frame count.
// cfg_we/cfg_wdata write the ring capacity and clear the ring; write only
// while idle.
// Allocate, finish and unused mode pass through the command queue and set the
// result register; release enters a release state that pops one frame per
// cycle through the frame queue read port, then sets the result register.
// One allocate or finish is executed per cycle while the result register is
// free; a release holds the back end until its result is set. A two-entry
// command queue keeps req accepting while a result waits; when rsp stalls the
// result register holds, the back end waits and a full queue drops req ready.
// Reset: capacity 65536, ring empty, frame queue empty.
`timescale 1ns / 1ps
`default_nettype none
module fenced_ring_space_allocator #(
	parameter int FRAME_QUEUE_DEPTH = frsa_pkg::FRAME_QUEUE_DEPTH_DEF,
	parameter int OFFSET_BITS       = frsa_pkg::OFFSET_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [frsa_pkg::CAP_W-1:0] cfg_wdata,
	frsa_req_if.sink                  req,
	frsa_rsp_if.source                rsp
);
	import frsa_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	frsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	frsa_back #(
		.FRAME_QUEUE_DEPTH (FRAME_QUEUE_DEPTH),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire
